// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Each one samples on the rising edge of
// clk and is disabled while rst_n is low, so the using module needs both.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge out of reset.
`define QK_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed: invariant");

// When the antecedent holds, the consequent holds in the same cycle.
`define QK_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// When the antecedent holds, the consequent holds in the next cycle.
`define QK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/qknob_pkg.sv =====
// ---------------------------------------------------------------------------
// qknob_pkg
// Shared widths, register indexes and word types of the quadrature knob with
// push button.
// ---------------------------------------------------------------------------
package qknob_pkg;

  // Position and edge count widths. The edge count holds span times the
  // largest step size (16), so it is five bits wider than a position, one more than the product needs.
  localparam int POS_W  = 16;
  localparam int TPC_W  = 5;
  localparam int SUB_W  = 4;
  localparam int EDGE_W = POS_W + TPC_W;
  localparam int DEB_W  = 8;
  localparam int PRESS_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Largest step size; smaller nonzero values are used as written.
  localparam logic [TPC_W-1:0] TPC_MAX = TPC_W'(16);

  // Register reset values.
  localparam logic signed [POS_W-1:0] MIN_POS_RST   = POS_W'(0);
  localparam logic signed [POS_W-1:0] MAX_POS_RST   = POS_W'(100);
  localparam logic signed [POS_W-1:0] START_POS_RST = POS_W'(0);
  localparam logic [TPC_W-1:0]        TPC_RST       = TPC_W'(4);
  localparam logic [DEB_W-1:0]        DEB_RST       = DEB_W'(20);
  localparam logic [PRESS_W-1:0]      LONG_RST      = PRESS_W'(800);

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_POS   = 3'd0,
    CFG_MAX_POS   = 3'd1,
    CFG_START_POS = 3'd2,
    CFG_TPC       = 3'd3,
    CFG_DEBOUNCE  = 3'd4,
    CFG_LONG      = 3'd5
  } cfg_idx_t;

  // Operation codes of an input word.
  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Register file contents as seen by the datapath.
  typedef struct packed {
    logic signed [POS_W-1:0] min_pos;
    logic signed [POS_W-1:0] max_pos;
    logic signed [POS_W-1:0] start_pos;
    logic [TPC_W-1:0]        ticks_per_click;
    logic [DEB_W-1:0]        debounce_ticks;
    logic [PRESS_W-1:0]      long_click_ticks;
  } cfg_t;

  // One input word: a millisecond tick.
  typedef struct packed {
    logic op;
    logic quad_a;
    logic quad_b;
    logic button_level;
    logic hold_position;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic                    position_changed;
    logic                    click;
    logic                    long_click;
    logic                    button_pressed;
  } out_word_t;

  // Encoder decoder result for the current tick.
  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic                    changed;
  } pos_res_t;

  // Button result for the current tick.
  typedef struct packed {
    logic click;
    logic long_click;
    logic pressed;
  } btn_res_t;

endpackage

// ===== sv/quadrature_knob_with_button.sv =====
// ---------------------------------------------------------------------------
// quadrature_knob_with_button
// Rotary knob decoder with a debounced push button, one word per tick.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one word per millisecond
//   tick: sampled phases A and B, the raw active-low button, a hold flag and
//   an op (sample or restart). Each input word gives exactly one result word
//   on the output channel (out_valid/out_ready/out_data).
//   Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) writes one
//   register per handshake and is always ready; write it while idle.
//   A word that is accepted sits in the input register, and its result is
//   loaded into the output register when that register is free or drains.
//   The block takes one word per cycle while the receiver keeps up; all
//   decoder and button updates are combinational counter steps registered on step.
//   When the receiver stalls, the result waits in the output register and
//   one more word is held in the input register; in_ready falls only while
//   both are full and out_ready is low.
//   Reset clears both registers, loads the register reset values and puts
//   the knob at position zero with the button released.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module quadrature_knob_with_button (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  qknob_pkg::in_word_t                     in_data,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output qknob_pkg::out_word_t                    out_data,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [qknob_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [qknob_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import qknob_pkg::*;

  cfg_t       cfg_r;
  in_word_t   in_word_r;
  logic       in_valid_r;
  out_word_t  out_word_r, out_word_nxt;
  logic       out_valid_r;
  logic       step;
  pos_res_t   pos_res;
  btn_res_t   btn_res;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_pos          <= MIN_POS_RST;
      cfg_r.max_pos          <= MAX_POS_RST;
      cfg_r.start_pos        <= START_POS_RST;
      cfg_r.ticks_per_click  <= TPC_RST;
      cfg_r.debounce_ticks   <= DEB_RST;
      cfg_r.long_click_ticks <= LONG_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MIN_POS:   cfg_r.min_pos          <= cfg_data;
        CFG_MAX_POS:   cfg_r.max_pos          <= cfg_data;
        CFG_START_POS: cfg_r.start_pos        <= cfg_data;
        CFG_TPC:       cfg_r.ticks_per_click  <= cfg_data[TPC_W-1:0];
        CFG_DEBOUNCE:  cfg_r.debounce_ticks   <= cfg_data[DEB_W-1:0];
        CFG_LONG:      cfg_r.long_click_ticks <= cfg_data[PRESS_W-1:0];
        default: ;
      endcase
    end
  end

  // The held word is processed when the output register is free or drains.
  assign step     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_word_r <= in_data;
    end
  end

  // Encoder and button datapaths work on the held word.
  qknob_quad u_quad (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .in_word (in_word_r),
    .cfg     (cfg_r),
    .res     (pos_res)
  );

  qknob_button u_button (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .in_word (in_word_r),
    .cfg     (cfg_r),
    .res     (btn_res)
  );

  // Assemble the result word.
  always_comb begin
    out_word_nxt.position         = pos_res.position;
    out_word_nxt.position_changed = pos_res.changed;
    out_word_nxt.click            = btn_res.click;
    out_word_nxt.long_click       = btn_res.long_click;
    out_word_nxt.button_pressed   = btn_res.pressed;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  // Every processed word shows up as a result in the next cycle.
  `QK_ASSERT_NEXT(a_step_fills_out, step, out_valid_r)
  // Backpressure only when both registers are full and the output stalls.
  `QK_ASSERT_IMPL(a_ready_only_blocked, !in_ready, in_valid_r && out_valid_r && !out_ready)

endmodule

// ===== sv/qknob_quad.sv =====
// ---------------------------------------------------------------------------
// qknob_quad
// 4x quadrature decoder with a clamped edge count and an incrementally kept
// logical position. The result for the word at the input is combinational;
// the state advances when step is high.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module qknob_quad (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  qknob_pkg::in_word_t in_word,
  input  qknob_pkg::cfg_t     cfg,
  output qknob_pkg::pos_res_t res
);
  import qknob_pkg::*;

  // Transition codes {previous A B, current A B} that count up or down.
  localparam logic [15:0] UP_SET   = 16'h2814;
  localparam logic [15:0] DOWN_SET = 16'h4182;

  logic [1:0]              phases_r, phases_nxt;
  logic [EDGE_W-1:0]       edge_r, edge_nxt;
  logic [SUB_W-1:0]        sub_r, sub_nxt;
  logic signed [POS_W-1:0] pos_r, pos_nxt;

  logic signed [POS_W-1:0] lo, hi, start_clamped;
  logic [POS_W-1:0]        span, start_off;
  logic [TPC_W-1:0]        tpc, sub_inc;
  logic [EDGE_W-1:0]       edge_cap, start_edges;
  logic [1:0]              phases;
  logic [3:0]              code;
  logic                    edge_step_ok;

  // Effective range and step size.
  always_comb begin
    lo  = cfg.min_pos;
    hi  = (cfg.max_pos < cfg.min_pos) ? cfg.min_pos : cfg.max_pos;
    if (cfg.ticks_per_click == '0) begin
      tpc = TPC_W'(1);
    end else if (cfg.ticks_per_click > TPC_MAX) begin
      tpc = TPC_MAX;
    end else begin
      tpc = cfg.ticks_per_click;
    end
    if (cfg.start_pos < lo) begin
      start_clamped = lo;
    end else if (cfg.start_pos > hi) begin
      start_clamped = hi;
    end else begin
      start_clamped = cfg.start_pos;
    end
  end

  // Offsets from the low end are never negative and fit POS_W unsigned bits,
  // so the products below fit the edge count without clamping.
  assign span        = POS_W'(hi - lo);
  assign start_off   = POS_W'(start_clamped - lo);
  assign edge_cap    = EDGE_W'(span) * EDGE_W'(tpc);
  assign start_edges = EDGE_W'(start_off) * EDGE_W'(tpc);

  assign phases  = {in_word.quad_a, in_word.quad_b};
  assign code    = {phases_r, phases};
  assign sub_inc = {1'b0, sub_r} + TPC_W'(1);

  // Next state of the decoder for the current word.
  always_comb begin
    phases_nxt = phases_r;
    edge_nxt   = edge_r;
    sub_nxt    = sub_r;
    pos_nxt    = pos_r;
    if (in_word.op == OP_RESTART) begin
      phases_nxt = phases;
      pos_nxt    = start_clamped;
      edge_nxt   = start_edges;
      sub_nxt    = '0;
    end else if (!in_word.hold_position && (phases != phases_r)) begin
      // Double jumps match neither set but still move the phase history.
      phases_nxt = phases;
      if (UP_SET[code]) begin
        if (edge_r < edge_cap) begin
          edge_nxt = edge_r + EDGE_W'(1);
          if (sub_inc >= tpc) begin
            sub_nxt = '0;
            if (pos_r < hi) begin
              pos_nxt = pos_r + POS_W'(1);
            end
          end else begin
            sub_nxt = sub_inc[SUB_W-1:0];
          end
        end
      end else if (DOWN_SET[code]) begin
        if (edge_r != '0) begin
          edge_nxt = edge_r - EDGE_W'(1);
          if (sub_r == '0) begin
            sub_nxt = SUB_W'(tpc - TPC_W'(1));
            if (pos_r > lo) begin
              pos_nxt = pos_r - POS_W'(1);
            end
          end else begin
            sub_nxt = sub_r - SUB_W'(1);
          end
        end
      end
    end
  end

  assign res.position = pos_nxt;
  assign res.changed  = (pos_nxt != pos_r);

  // Decoder state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phases_r <= '0;
      edge_r   <= '0;
      sub_r    <= '0;
      pos_r    <= MIN_POS_RST;
    end else if (step) begin
      phases_r <= phases_nxt;
      edge_r   <= edge_nxt;
      sub_r    <= sub_nxt;
      pos_r    <= pos_nxt;
    end
  end

  // The next edge count stays within one of the current one.
  assign edge_step_ok = (edge_nxt == edge_r) || (edge_nxt == edge_r + EDGE_W'(1)) ||
                        (edge_nxt == edge_r - EDGE_W'(1));

  // A sample word moves the edge count by at most one.
  `QK_ASSERT_IMPL(a_edge_single_step, step && (in_word.op == OP_SAMPLE), edge_step_ok)
  // The position only changes on a step.
  `QK_ASSERT_NEXT(a_pos_holds, !step, pos_r == $past(pos_r))

endmodule

// ===== sv/qknob_button.sv =====
// ---------------------------------------------------------------------------
// qknob_button
// Debounce of the active-low button by stable-tick counting, with a click on
// release after a short press and a one-shot long click while held.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module qknob_button (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  qknob_pkg::in_word_t in_word,
  input  qknob_pkg::cfg_t     cfg,
  output qknob_pkg::btn_res_t res
);
  import qknob_pkg::*;

  logic                 raw_prev_r, raw_prev_nxt;
  logic                 stable_r, stable_nxt;
  logic [DEB_W-1:0]     stable_cnt_r, stable_cnt_nxt;
  logic [PRESS_W-1:0]   press_r, press_nxt;
  logic                 long_done_r, long_done_nxt;
  logic                 click, long_click;
  logic                 reading;

  assign reading = in_word.button_level;

  // Debounce and press timing for the current word.
  always_comb begin
    click         = 1'b0;
    long_click    = 1'b0;
    stable_nxt    = stable_r;
    long_done_nxt = long_done_r;
    raw_prev_nxt  = reading;
    press_nxt     = press_r;
    if (!stable_r && (press_r != '1)) begin
      press_nxt = press_r + PRESS_W'(1);
    end
    if (reading != raw_prev_r) begin
      stable_cnt_nxt = '0;
    end else if (stable_cnt_r != '1) begin
      stable_cnt_nxt = stable_cnt_r + DEB_W'(1);
    end else begin
      stable_cnt_nxt = stable_cnt_r;
    end
    // A saturated count counts as stable whatever the threshold.
    if ((stable_cnt_nxt > cfg.debounce_ticks) || (stable_cnt_nxt == '1)) begin
      if (reading != stable_r) begin
        stable_nxt = reading;
        if (!reading) begin
          press_nxt     = '0;
          long_done_nxt = 1'b0;
        end else if (!long_done_r) begin
          click = 1'b1;
        end
      end
      if (!stable_nxt && !long_done_nxt && (press_nxt >= cfg.long_click_ticks)) begin
        long_click    = 1'b1;
        long_done_nxt = 1'b1;
      end
    end
  end

  assign res.click      = click;
  assign res.long_click = long_click;
  assign res.pressed    = !stable_nxt;

  // Button state; the button is taken as released at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_prev_r   <= 1'b1;
      stable_r     <= 1'b1;
      stable_cnt_r <= '0;
      press_r      <= '0;
      long_done_r  <= 1'b0;
    end else if (step) begin
      raw_prev_r   <= raw_prev_nxt;
      stable_r     <= stable_nxt;
      stable_cnt_r <= stable_cnt_nxt;
      press_r      <= press_nxt;
      long_done_r  <= long_done_nxt;
    end
  end

  // A release click and a long click never fall on the same word.
  `QK_ASSERT_ALWAYS(a_click_exclusive, !(res.click && res.long_click))
  // A taken long click arms the one-shot guard.
  `QK_ASSERT_NEXT(a_long_sets_done, step && res.long_click, long_done_r)

endmodule

// ===== verif/quadrature_knob_with_button_tb.sv =====
// ---------------------------------------------------------------------------
// quadrature_knob_with_button_tb
// Self-checking bench for the knob decoder with debounced push button. A
// scoreboard class models the quadrature counter and the button debouncer
// and checks every result word in order. Plain tasks drive the tick and
// register channels, with random gaps between ticks; a receiver block stalls the result channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module quadrature_knob_with_button_tb;
  import qknob_pkg::*;

  localparam int SETTLE_CYCLES = 4;
  localparam int TIMEOUT_NS    = 4_000_000;
  localparam int MAX_REPORTS   = 10;

  // Transition codes {previous phases, new phases} that step up or down.
  localparam bit [15:0] STEP_UP_CODES   = 16'h2814;
  localparam bit [15:0] STEP_DOWN_CODES = 16'h4182;
  localparam int        EDGE_LIMIT      = 2097151;
  localparam int        PRESS_LIMIT     = 65535;
  localparam int        STABLE_LIMIT    = 255;

  // Phase levels {a,b} in the order of upward rotation: 00, 10, 11, 01.
  localparam bit [7:0] QUAD_SEQ = {2'b01, 2'b11, 2'b10, 2'b00};

  // Scoreboard: models the knob and holds the result words still due.
  class knob_scoreboard;
    cfg_t        regs;
    logic [1:0]  prev_ph;
    int          edges;
    int          sub;
    int          position;
    bit          raw_prev;
    bit          stable_btn;
    int          stable_cnt;
    int          press_cnt;
    bit          long_done;
    out_word_t   words_due[$];
    int          failures;
    int          words_checked;
    int          clicks_seen;
    int          long_clicks_seen;
    int          moves_seen;

    function new();
      regs = '{min_pos: MIN_POS_RST, max_pos: MAX_POS_RST, start_pos: START_POS_RST,
               ticks_per_click: TPC_RST, debounce_ticks: DEB_RST,
               long_click_ticks: LONG_RST};
      prev_ph    = 2'b00;
      edges      = 0;
      sub        = 0;
      position   = MIN_POS_RST;
      raw_prev   = 1'b1;
      stable_btn = 1'b1;
      stable_cnt = 0;
      press_cnt  = 0;
      long_done  = 1'b0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MIN_POS:   regs.min_pos = data;
        CFG_MAX_POS:   regs.max_pos = data;
        CFG_START_POS: regs.start_pos = data;
        CFG_TPC:       regs.ticks_per_click = data[TPC_W-1:0];
        CFG_DEBOUNCE:  regs.debounce_ticks = data[DEB_W-1:0];
        CFG_LONG:      regs.long_click_ticks = data;
        default: ;
      endcase
    endfunction

    // Advance the knob by one accepted tick and queue the result word.
    function void note_tick(in_word_t w);
      int         lo;
      int         hi;
      int         step;
      int         pos_prev;
      int         s;
      int         span_edges;
      int         code;
      logic [1:0] ph;
      out_word_t  res;
      lo = regs.min_pos;
      hi = regs.max_pos;
      // An inverted range collapses onto the minimum.
      if (hi < lo) hi = lo;
      step = regs.ticks_per_click;
      if (step == 0) step = 1;
      else if (step > 16) step = 16;
      pos_prev = position;
      ph = {w.quad_a, w.quad_b};
      res = '0;

      // Encoder: restart loads the clamped start position and the phases.
      if (w.op == OP_RESTART) begin
        s = regs.start_pos;
        if (s < lo) s = lo;
        if (s > hi) s = hi;
        position = s;
        edges = (s - lo) * step;
        if (edges > EDGE_LIMIT) edges = EDGE_LIMIT;
        sub = 0;
        prev_ph = ph;
      end else if (!w.hold_position && ph != prev_ph) begin
        code = {prev_ph, ph};
        span_edges = (hi - lo) * step;
        if (span_edges > EDGE_LIMIT) span_edges = EDGE_LIMIT;
        if (STEP_UP_CODES[code]) begin
          if (edges < span_edges) begin
            edges++;
            sub++;
            if (sub >= step) begin
              sub = 0;
              if (position < hi) position++;
            end
          end
        end else if (STEP_DOWN_CODES[code]) begin
          if (edges > 0) begin
            edges--;
            if (sub == 0) begin
              sub = step - 1;
              if (position > lo) position--;
            end else begin
              sub--;
            end
          end
        end
        // A double jump moves nothing but still updates the phases.
        prev_ph = ph;
      end

      // Button: count the press, then debounce on stable ticks.
      if (!stable_btn && press_cnt < PRESS_LIMIT) press_cnt++;
      if (w.button_level != raw_prev) stable_cnt = 0;
      else if (stable_cnt < STABLE_LIMIT) stable_cnt++;
      if (stable_cnt > regs.debounce_ticks || stable_cnt == STABLE_LIMIT) begin
        if (w.button_level != stable_btn) begin
          stable_btn = w.button_level;
          if (!stable_btn) begin
            press_cnt = 0;
            long_done = 1'b0;
          end else if (!long_done) begin
            res.click = 1'b1;
          end
        end
        if (!stable_btn && !long_done && press_cnt >= regs.long_click_ticks) begin
          res.long_click = 1'b1;
          long_done = 1'b1;
        end
      end
      raw_prev = w.button_level;

      res.position         = position[POS_W-1:0];
      res.position_changed = (position != pos_prev);
      res.button_pressed   = !stable_btn;
      words_due.push_back(res);
    endfunction

    // Compare one accepted result word with the oldest word due.
    function void check_word(out_word_t got);
      out_word_t want;
      bit        bad;
      if (words_due.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("result word with none due: position %0d click %0b long %0b",
                   got.position, got.click, got.long_click);
        return;
      end
      want = words_due.pop_front();
      words_checked++;
      if (want.click) clicks_seen++;
      if (want.long_click) long_clicks_seen++;
      if (want.position_changed) moves_seen++;
      bad = (got.position !== want.position) ||
            (got.position_changed !== want.position_changed) ||
            (got.click !== want.click) || (got.long_click !== want.long_click) ||
            (got.button_pressed !== want.button_pressed);
      if (bad) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("mismatch at word %0d (expected/actual): position %0d/%0d changed %0b/%0b",
                   words_checked, want.position, got.position,
                   want.position_changed, got.position_changed);
          $display("  click %0b/%0b long %0b/%0b pressed %0b/%0b",
                   want.click, got.click, want.long_click, got.long_click,
                   want.button_pressed, got.button_pressed);
        end
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_word_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_word_t  out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  knob_scoreboard sb;
  int  ticks_sent;
  int  settings_used;
  int  rx_stall_req;
  bit  rx_steady;
  bit  tx_steady;
  int  enc_idx;
  int  knob_dir;
  bit  btn_level;
  int  btn_left;
  int  btn_bounce;

  quadrature_knob_with_button u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Handshake monitor: note accepted ticks, check accepted result words.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_tick(in_data);
        ticks_sent++;
      end
      if (out_valid && out_ready) sb.check_word(out_data);
    end
  end

  // Receiver: random stall before each word, or a long requested hold-off.
  initial begin : receiver
    int n;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (rx_stall_req != 0) begin
        n = rx_stall_req;
        rx_stall_req = 0;
      end else begin
        n = rx_steady ? 0 : $urandom_range(0, 15);
      end
      if (n > 0) begin
        out_ready = 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Run limit.
  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

  function automatic in_word_t tick_word(logic op, logic a, logic b, logic btn, logic hold);
    in_word_t w;
    w.op = op;
    w.quad_a = a;
    w.quad_b = b;
    w.button_level = btn;
    w.hold_position = hold;
    return w;
  endfunction

  // Human-like button: presses short and long against the current
  // debounce and long-click settings, with contact bounce and rare glitches.
  function automatic bit next_button();
    int d;
    int l;
    d = sb.regs.debounce_ticks;
    l = sb.regs.long_click_ticks;
    if (btn_left == 0) begin
      btn_level = !btn_level;
      btn_bounce = $urandom_range(0, 3);
      if (!btn_level) begin
        if ($urandom_range(0, 1) == 1) btn_left = d + 6 + $urandom_range(0, 12);
        else btn_left = d + l + $urandom_range(6, 24);
      end else begin
        btn_left = d + 6 + $urandom_range(0, 15);
      end
    end
    btn_left--;
    if (btn_bounce > 0) begin
      btn_bounce--;
      return 1'($urandom_range(0, 1));
    end
    if ($urandom_range(0, 99) == 0) return !btn_level;
    return btn_level;
  endfunction

  // Mostly clean rotation in runs, with rests, holds, double jumps and
  // occasional restarts.
  function automatic in_word_t random_tick();
    in_word_t w;
    int       r;
    r = $urandom_range(0, 99);
    w = '0;
    w.op = OP_SAMPLE;
    if (r < 3) begin
      w.op = OP_RESTART;
      enc_idx = $urandom_range(0, 3);
      w.hold_position = 1'($urandom_range(0, 1));
    end else if (r < 7) begin
      enc_idx = (enc_idx + 2) % 4;
    end else if (r < 12) begin
      w.hold_position = 1'b1;
      if ($urandom_range(0, 1) == 1) enc_idx = (enc_idx + 1) % 4;
    end else if (r >= 30) begin
      if ($urandom_range(0, 31) == 0) knob_dir = -knob_dir;
      enc_idx = (enc_idx + 4 + knob_dir) % 4;
    end
    {w.quad_a, w.quad_b} = QUAD_SEQ[enc_idx*2 +: 2];
    w.button_level = next_button();
    return w;
  endfunction

  // Offer one tick word after a gap; returns at the falling edge after
  // acceptance with valid still high.
  task automatic send_tick(input in_word_t w, input int gap);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data = w;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Stop offering and wait until every result word due has arrived.
  task automatic drain();
    in_valid = 1'b0;
    while (sb.words_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
    @(negedge clk);
  endtask

  task automatic set_knob(input int lo, input int hi, input int start, input int tpc,
                          input int deb, input int lng);
    drain();
    cfg_write(CFG_MIN_POS, CFG_DATA_W'(lo));
    cfg_write(CFG_MAX_POS, CFG_DATA_W'(hi));
    cfg_write(CFG_START_POS, CFG_DATA_W'(start));
    cfg_write(CFG_TPC, CFG_DATA_W'(tpc));
    cfg_write(CFG_DEBOUNCE, CFG_DATA_W'(deb));
    cfg_write(CFG_LONG, CFG_DATA_W'(lng));
    // A very long press from an earlier setting ends soon under the new one.
    if (btn_left > 30) btn_left = 30;
    settings_used++;
  endtask

  // Random ticks under the current setting.
  task automatic run_phase(input int n, input bit restart_first, input bit steady);
    in_word_t w;
    int       gap;
    rx_steady = ($urandom_range(0, 3) == 0);
    knob_dir = ($urandom_range(0, 1) == 1) ? 1 : -1;
    if (restart_first) begin
      w = random_tick();
      w.op = OP_RESTART;
      send_tick(w, 0);
    end
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) tx_steady = ($urandom_range(0, 3) == 0);
      gap = (steady || tx_steady) ? 0 : $urandom_range(0, 15);
      send_tick(random_tick(), gap);
    end
  endtask

  initial begin : stimulus
    int lo;
    int hi;
    int start;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MIN_POS;
    cfg_data = '0;
    rx_stall_req = 0;
    rx_steady = 1'b0;
    tx_steady = 1'b0;
    enc_idx = 0;
    knob_dir = 1;
    btn_level = 1'b1;
    btn_left = 30;
    btn_bounce = 0;
    ticks_sent = 0;
    settings_used = 1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: one click up, back down to zero and against the floor, double jumps, hold,
    // restart with hold set, and every field at both levels.
    send_tick(tick_word(OP_SAMPLE, 1'b0, 1'b0, 1'b1, 1'b0), $urandom_range(0, 15));
    send_tick(tick_word(OP_SAMPLE, 1'b1, 1'b0, 1'b1, 1'b0), $urandom_range(0, 15));
    send_tick(tick_word(OP_SAMPLE, 1'b1, 1'b1, 1'b1, 1'b0), $urandom_range(0, 15));
    send_tick(tick_word(OP_SAMPLE, 1'b0, 1'b1, 1'b1, 1'b0), $urandom_range(0, 15));
    send_tick(tick_word(OP_SAMPLE, 1'b0, 1'b0, 1'b1, 1'b0), $urandom_range(0, 15));
    send_tick(tick_word(OP_SAMPLE, 1'b0, 1'b1, 1'b1, 1'b0), $urandom_range(0, 15));
    send_tick(tick_word(OP_SAMPLE, 1'b1, 1'b1, 1'b1, 1'b0), $urandom_range(0, 15));
    send_tick(tick_word(OP_SAMPLE, 1'b1, 1'b0, 1'b1, 1'b0), $urandom_range(0, 15));
    send_tick(tick_word(OP_SAMPLE, 1'b0, 1'b0, 1'b1, 1'b0), $urandom_range(0, 15));
    send_tick(tick_word(OP_SAMPLE, 1'b0, 1'b1, 1'b1, 1'b0), $urandom_range(0, 15));
    send_tick(tick_word(OP_SAMPLE, 1'b1, 1'b0, 1'b1, 1'b0), $urandom_range(0, 15));
    send_tick(tick_word(OP_SAMPLE, 1'b1, 1'b1, 1'b1, 1'b1), $urandom_range(0, 15));
    send_tick(tick_word(OP_SAMPLE, 1'b0, 1'b1, 1'b1, 1'b0), $urandom_range(0, 15));
    send_tick(tick_word(OP_RESTART, 1'b1, 1'b1, 1'b0, 1'b1), $urandom_range(0, 15));
    send_tick(tick_word(OP_SAMPLE, 1'b1, 1'b0, 1'b0, 1'b1), $urandom_range(0, 15));
    send_tick(tick_word(OP_SAMPLE, 1'b0, 1'b0, 1'b0, 1'b0), $urandom_range(0, 15));
    send_tick(tick_word(OP_SAMPLE, 1'b0, 1'b1, 1'b0, 1'b0), 0);
    send_tick(tick_word(OP_SAMPLE, 1'b1, 1'b1, 1'b1, 1'b0), 0);
    send_tick(tick_word(OP_RESTART, 1'b0, 1'b0, 1'b1, 1'b0), 0);

    // Small range, then a shrunk range and step size without a restart.
    set_knob(0, 10, 5, 4, 3, 30);
    run_phase(100, 1'b1, 1'b0);
    drain();
    cfg_write(CFG_TPC, CFG_DATA_W'(3));
    cfg_write(CFG_MAX_POS, CFG_DATA_W'(2));
    run_phase(80, 1'b0, 1'b0);

    // Full range, step of one, no debounce and an immediate long click.
    set_knob(-32768, 32767, 0, 1, 0, 0);
    run_phase(100, 1'b1, 1'b0);

    // Inverted range with the largest step.
    set_knob(10, 5, 7, 16, 5, 40);
    run_phase(80, 1'b1, 1'b0);

    // Step size zero, start below the range.
    set_knob(-5, 5, -100, 0, 1, 10);
    run_phase(100, 1'b1, 1'b0);

    // Step size above the largest, top of the range, long clicks unreachable.
    set_knob(32760, 32767, 32767, 31, 2, 65535);
    run_phase(100, 1'b1, 1'b0);

    // Bottom of the range, start above it, saturated debounce.
    set_knob(-32768, -32760, 32767, 7, 255, 40);
    run_phase(650, 1'b1, 1'b0);

    // Receiver holds off while the sender keeps offering back to back.
    set_knob(0, 20, 10, 2, 2, 15);
    rx_stall_req = 100;
    run_phase(60, 1'b1, 1'b1);

    // Random small settings.
    repeat (3) begin
      lo = $urandom_range(0, 400);
      lo = lo - 200;
      hi = lo + $urandom_range(0, 40);
      if ($urandom_range(0, 9) == 0) hi = lo - 3;
      start = lo + $urandom_range(0, 60);
      start = start - 10;
      set_knob(lo, hi, start, $urandom_range(0, 31), $urandom_range(0, 10),
               $urandom_range(0, 100));
      run_phase(100, 1'b1, 1'b0);
    end

    drain();
    $display("Sent %0d ticks under %0d register settings; checked %0d result words.",
             ticks_sent, settings_used, sb.words_checked);
    $display("Seen %0d position moves, %0d clicks and %0d long clicks; %0d failures.",
             sb.moves_seen, sb.clicks_seen, sb.long_clicks_seen, sb.failures);
    if (sb.failures == 0 && sb.words_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/qknob_pkg.sv
sv/qknob_quad.sv
sv/qknob_button.sv
sv/quadrature_knob_with_button.sv
verif/quadrature_knob_with_button_tb.sv
